@@ hdl/kpe_pkg.sv @@
// shared types and constants for the key press event detector
`timescale 1ns / 1ps
`default_nettype none

package kpe_pkg;

  localparam int KEY_W     = 4;
  localparam int CODE_W    = 3;
  localparam int CNT_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int KEY_BITS_DEFAULT = 4;

  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 8;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [CNT_W-1:0] DEBOUNCE_RESET   = CNT_W'(2);
  localparam logic [CNT_W-1:0] LONG_PRESS_RESET = CNT_W'(100);
  localparam logic [CNT_W-1:0] REPEAT_RESET     = CNT_W'(20);

  typedef enum logic [CODE_W-1:0] {
    EV_NONE     = 3'd0,
    EV_PRESS    = 3'd1,
    EV_SHORT    = 3'd2,
    EV_LONG     = 3'd3,
    EV_REPEAT   = 3'd4,
    EV_LONG_REL = 3'd5
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_REPEAT     = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0] debounce_ticks;
    logic [CNT_W-1:0] long_press_ticks;
    logic [CNT_W-1:0] repeat_ticks;
  } cfg_t;

  typedef struct packed {
    event_t           event_code;
    logic [KEY_W-1:0] event_key;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/kpe_cfg.sv @@
// configuration registers for the key press event detector
`timescale 1ns / 1ps
`default_nettype none

module kpe_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [kpe_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [kpe_pkg::CNT_W-1:0]     cfg_wdata,
  output kpe_pkg::cfg_t                      cfg
);
  import kpe_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= DEBOUNCE_RESET;
      cfg.long_press_ticks <= LONG_PRESS_RESET;
      cfg.repeat_ticks     <= REPEAT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_DEBOUNCE:   cfg.debounce_ticks   <= cfg_wdata;
        REG_LONG_PRESS: cfg.long_press_ticks <= cfg_wdata;
        REG_REPEAT:     cfg.repeat_ticks     <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/kpe_fsm.sv @@
// input register and press/hold state machine
`timescale 1ns / 1ps
`default_nettype none

module kpe_fsm #(
  parameter int KEY_BITS = kpe_pkg::KEY_BITS_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  kpe_pkg::cfg_t                  cfg,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [kpe_pkg::KEY_W-1:0] in_key,
  output logic                           res_valid,
  input  wire logic                      res_ready,
  output kpe_pkg::result_t               res
);
  import kpe_pkg::*;

  // tracked key keeps only the low KEY_BITS bits of the key (at most KEY_W)
  localparam int KeyW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

  typedef enum logic [1:0] {
    PH_IDLE, PH_DEBOUNCE, PH_PRESSED, PH_LONG
  } phase_t;

  phase_t            phase, phase_next;
  logic [KeyW-1:0]   tracked_key, tracked_key_next;
  logic [CNT_W-1:0]  tick_count, tick_count_next;
  logic              key_valid;
  logic [KeyW-1:0]   key_q;
  logic              step;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  limit;
  logic              expired;
  event_t            ev;

  assign step      = key_valid && res_ready;
  assign in_ready  = !key_valid || res_ready;
  assign res_valid = key_valid;

  assign cnt_inc = (tick_count == CNT_MAX) ? tick_count : tick_count + CNT_W'(1);

  always_comb begin
    unique case (phase)
      PH_DEBOUNCE: limit = cfg.debounce_ticks;
      PH_PRESSED:  limit = cfg.long_press_ticks;
      default:     limit = cfg.repeat_ticks;
    endcase
  end

  // a zero limit fires on the first tick since the count is already past it
  assign expired = cnt_inc >= limit;

  always_comb begin
    phase_next       = phase;
    tracked_key_next = tracked_key;
    tick_count_next  = tick_count;
    ev               = EV_NONE;
    unique case (phase)
      PH_IDLE: begin
        if (key_q != '0) begin
          tracked_key_next = key_q;
          tick_count_next  = '0;
          phase_next       = PH_DEBOUNCE;
        end
      end
      default: begin
        if (key_q != tracked_key) begin
          // any change counts as a release; new key picked up next tick
          phase_next = PH_IDLE;
          unique case (phase)
            PH_PRESSED: ev = EV_SHORT;
            PH_LONG:    ev = EV_LONG_REL;
            default:    ev = EV_NONE;
          endcase
        end else if (expired) begin
          tick_count_next = '0;
          unique case (phase)
            PH_DEBOUNCE: begin
              phase_next = PH_PRESSED;
              ev         = EV_PRESS;
            end
            PH_PRESSED: begin
              phase_next = PH_LONG;
              ev         = EV_LONG;
            end
            default: ev = EV_REPEAT;
          endcase
        end else begin
          tick_count_next = cnt_inc;
        end
      end
    endcase
  end

  assign res.event_code = ev;
  assign res.event_key  = (ev == EV_NONE) ? '0 : KEY_W'(tracked_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid   <= 1'b0;
      phase       <= PH_IDLE;
      tracked_key <= '0;
      tick_count  <= '0;
    end else begin
      if (in_ready) begin
        key_valid <= in_valid;
        if (in_valid) begin
          key_q <= in_key[KeyW-1:0];
        end
      end
      if (step) begin
        phase       <= phase_next;
        tracked_key <= tracked_key_next;
        tick_count  <= tick_count_next;
      end
    end
  end

  a_tracked_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase != PH_IDLE |-> tracked_key != '0)
    else $error("tracked key is zero outside idle");

  a_change_goes_idle: assert property (@(posedge clk) disable iff (rst)
    step && phase != PH_IDLE && key_q != tracked_key |=> phase == PH_IDLE)
    else $error("key change did not return to idle");

  a_timer_restart: assert property (@(posedge clk) disable iff (rst)
    step && (ev == EV_PRESS || ev == EV_LONG || ev == EV_REPEAT) |=> tick_count == '0)
    else $error("timer not restarted after timed event");

  a_hold_state: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase) && $stable(tick_count))
    else $error("state moved without a beat");

endmodule

`default_nettype wire

@@ hdl/kpe_out.sv @@
// result register driving the output stream
`timescale 1ns / 1ps
`default_nettype none

module kpe_out (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              res_valid,
  output logic                                   res_ready,
  input  kpe_pkg::result_t                       res,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [kpe_pkg::M_TDATA_W-1:0]          m_axis_tdata
);
  import kpe_pkg::*;

  result_t res_q;

  assign res_ready    = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata = M_TDATA_W'({res_q.event_key, res_q.event_code});

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
      if (res_valid) begin
        res_q <= res;
      end
    end
  end

  a_no_key_without_event: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && res_q.event_code == EV_NONE |-> res_q.event_key == '0)
    else $error("key reported with no event");

  a_valid_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> res_q.event_code <= EV_LONG_REL)
    else $error("event code out of range");

endmodule

`default_nettype wire

@@ hdl/key_press_event_detector_top.sv @@
// key press event detector: debounce, short/long press and hold repeat
// result path: each input beat is registered in the fsm input register, then in the output register
// throughput: one beat per cycle while m_axis_tready does not stall; the state register updates once per beat
// in a single pass through the phase/timer logic
// reset (rst, synchronous): phase idle, tracked key and timer cleared,
// registers back to debounce 2, long press 100, repeat 20, no beat in flight
`timescale 1ns / 1ps
`default_nettype none

module key_press_event_detector_top #(
  parameter int KEY_BITS = kpe_pkg::KEY_BITS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [kpe_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [kpe_pkg::CNT_W-1:0]     cfg_wdata,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [kpe_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [3:0] key_code
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [kpe_pkg::M_TDATA_W-1:0]      m_axis_tdata   // [2:0] event_code, [6:3] event_key
);
  import kpe_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    res_valid;
  logic    res_ready;

  kpe_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  kpe_fsm #(
    .KEY_BITS (KEY_BITS)
  ) u_fsm (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_key    (s_axis_tdata[KEY_W-1:0]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  kpe_out u_out (
    .clk           (clk),
    .rst           (rst),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire
